// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pcibar_pkg.sv
// ---------------------------------------------------------------------------
// pcibar_pkg
// Types, codes and fixed constants of the type-0 config space and BAR decoder
// ---------------------------------------------------------------------------
package pcibar_pkg;

    // operation codes
    localparam logic [1:0] OP_CFG_READ  = 2'd0;
    localparam logic [1:0] OP_CFG_WRITE = 2'd1;
    localparam logic [1:0] OP_MEM_READ  = 2'd2;
    localparam logic [1:0] OP_MEM_WRITE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_TYPE0    = 3'd1;
    localparam logic [2:0] ST_CFG_BOUNDS   = 3'd2;
    localparam logic [2:0] ST_NO_HIT       = 3'd3;
    localparam logic [2:0] ST_BEYOND_BAR   = 3'd4;
    localparam logic [2:0] ST_MEM_DISABLED = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BARS_IN_USE   = 3'd0;
    localparam logic [2:0] CFG_WIDE_BAR_MODE = 3'd1;
    localparam logic [2:0] CFG_BAR_SIZE_0    = 3'd2;

    // fixed limits and config space layout
    localparam int MAX_BARS         = 6;
    localparam int MAX_ACCESS_BYTES = 8;
    localparam int CMD_BYTE         = 4;
    localparam int MSE_BIT          = 1;
    localparam int BAR_AREA         = 16;
    localparam int BAR_AREA_BYTES   = 24;
    localparam int BAR_LOW_BITS     = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic        is_type0;
        logic [11:0] reg_offset;
        logic [63:0] mem_address;
        logic [3:0]  byte_count;
        logic [63:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_data;
        logic [2:0]  hit_bar;
        logic [63:0] bar_offset;
        logic [63:0] forward_data;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic rd_issue;
        logic rd_capture;
        logic wr_byte;
        logic bar_step;
        logic load_out;
    } pcibar_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_mem;
        logic is_write;
        logic cfg_fail;
        logic count_zero;
        logic byte_last;
        logic bar_none;
        logic bar_hit;
        logic bar_last;
    } pcibar_stat_t;

endpackage

// File: rtl/core/pcibar_ctrl.sv
// ---------------------------------------------------------------------------
// pcibar_ctrl
// Sequencer: clearing pass, byte loop for config ops, BAR search, result load
// ---------------------------------------------------------------------------
module pcibar_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  pcibar_pkg::pcibar_stat_t stat,
    output pcibar_pkg::pcibar_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECODE  = 8'b0000_0100,
        S_CFG_RD  = 8'b0000_1000,
        S_CFG_RDW = 8'b0001_0000,
        S_CFG_WR  = 8'b0010_0000,
        S_BAR     = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_mem)
                begin
                    state_next = S_BAR;
                end
                else if (stat.cfg_fail || stat.count_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.is_write)
                begin
                    state_next = S_CFG_WR;
                end
                else
                begin
                    state_next = S_CFG_RD;
                end
            end
            S_CFG_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_CFG_RDW;
            end
            S_CFG_RDW:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = stat.byte_last ? S_FINISH : S_CFG_RD;
            end
            S_CFG_WR:
            begin
                cmd.wr_byte = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_BAR:
            begin
                if (stat.bar_none)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.bar_step = 1'b1;
                    if (stat.bar_hit || stat.bar_last)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/pcibar_dpath.sv
// ---------------------------------------------------------------------------
// pcibar_dpath
// Config space memory, BAR shadows, shared BAR comparator and result register
// ---------------------------------------------------------------------------
module pcibar_dpath #(
    parameter int CONFIG_BYTES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcibar_pkg::pcibar_cmd_t cmd,
    output pcibar_pkg::pcibar_stat_t stat,
    input  pcibar_pkg::in_item_t    item,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_wdata,
    output pcibar_pkg::out_item_t   result
);

    localparam int          AW        = $clog2(CONFIG_BYTES);
    localparam logic [12:0] CFG_LIMIT = 13'(CONFIG_BYTES);
    localparam int          WIDE_BARS = pcibar_pkg::MAX_BARS / 2;

    // configuration registers
    logic [2:0]  bars_in_use_reg;
    logic        wide_bar_mode_reg;
    logic [31:0] bar_size_reg [pcibar_pkg::MAX_BARS];

    // item and progress registers
    pcibar_pkg::in_item_t  item_reg;
    pcibar_pkg::out_item_t out_reg, out_next;
    logic [2:0]  byte_idx_reg;
    logic [2:0]  bar_idx_reg;
    logic [63:0] acc_reg;
    logic [7:0]  rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic        found_reg;
    logic [2:0]  hit_idx_reg;
    logic [31:0] hit_off_reg;
    logic [31:0] hit_size_reg;

    // shadows of command byte and BAR bytes
    logic [7:0] cmd_shadow_reg;
    logic [7:0] bar_shadow_reg [pcibar_pkg::BAR_AREA_BYTES];

    logic [7:0] cfg_mem [CONFIG_BYTES];

    logic          is_mem, is_write;
    logic [12:0]   cfg_end;
    logic [12:0]   byte_addr_full;
    logic [AW-1:0] byte_addr;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_we;
    logic [7:0]    wr_byte_val;
    logic [2:0]    cfg_status;
    logic [2:0]    mem_status;
    logic [2:0]    cap, limit;
    logic [63:0]   base_narrow [pcibar_pkg::MAX_BARS];
    logic [63:0]   base_wide [WIDE_BARS];
    logic [63:0]   base_cur;
    logic [31:0]   size_cur;
    logic [64:0]   diff;
    logic          bar_hit;
    logic          count_over;
    logic [31:0]   room;
    logic [63:0]   fwd_mask;

    // item decode
    always_comb
    begin
        is_mem   = (item_reg.operation == pcibar_pkg::OP_MEM_READ) ||
                   (item_reg.operation == pcibar_pkg::OP_MEM_WRITE);
        is_write = (item_reg.operation == pcibar_pkg::OP_CFG_WRITE) ||
                   (item_reg.operation == pcibar_pkg::OP_MEM_WRITE);
        count_over = item_reg.byte_count > 4'(pcibar_pkg::MAX_ACCESS_BYTES);
        cfg_end  = {1'b0, item_reg.reg_offset} + 13'(item_reg.byte_count);
        if (!item_reg.is_type0)
        begin
            cfg_status = pcibar_pkg::ST_NOT_TYPE0;
        end
        else if (count_over || (cfg_end > CFG_LIMIT))
        begin
            cfg_status = pcibar_pkg::ST_CFG_BOUNDS;
        end
        else
        begin
            cfg_status = pcibar_pkg::ST_OK;
        end
        byte_addr_full = {1'b0, item_reg.reg_offset} + 13'(byte_idx_reg);
        byte_addr      = byte_addr_full[AW-1:0];
        wr_byte_val    = item_reg.write_data[{byte_idx_reg, 3'b000} +: 8];
    end

    // candidate bases from shadow bytes, low bits masked
    always_comb
    begin
        for (int i = 0; i < pcibar_pkg::MAX_BARS; i++)
        begin
            base_narrow[i] = '0;
            for (int k = 0; k < 4; k++)
            begin
                base_narrow[i][8*k +: 8] = bar_shadow_reg[4*i + k];
            end
            base_narrow[i][pcibar_pkg::BAR_LOW_BITS-1:0] = '0;
        end
        for (int i = 0; i < WIDE_BARS; i++)
        begin
            base_wide[i] = '0;
            for (int k = 0; k < 8; k++)
            begin
                base_wide[i][8*k +: 8] = bar_shadow_reg[8*i + k];
            end
            base_wide[i][pcibar_pkg::BAR_LOW_BITS-1:0] = '0;
        end
    end

    // shared comparator for the BAR under test
    always_comb
    begin
        cap      = wide_bar_mode_reg ? 3'(WIDE_BARS) : 3'(pcibar_pkg::MAX_BARS);
        limit    = (bars_in_use_reg > cap) ? cap : bars_in_use_reg;
        base_cur = wide_bar_mode_reg ? base_wide[bar_idx_reg[1:0]] : base_narrow[bar_idx_reg];
        size_cur = bar_size_reg[bar_idx_reg];
        diff     = {1'b0, item_reg.mem_address} - {1'b0, base_cur};
        bar_hit  = !diff[64] && (diff[63:32] == 32'd0) && (diff[31:0] <= size_cur);
    end

    // status to controller
    always_comb
    begin
        stat.clear_last = (clr_addr_reg == AW'(CONFIG_BYTES - 1));
        stat.is_mem     = is_mem;
        stat.is_write   = is_write;
        stat.cfg_fail   = (cfg_status != pcibar_pkg::ST_OK);
        stat.count_zero = (item_reg.byte_count == 4'd0);
        stat.byte_last  = ({1'b0, byte_idx_reg} + 4'd1) == item_reg.byte_count;
        stat.bar_none   = (limit == 3'd0);
        stat.bar_hit    = bar_hit;
        stat.bar_last   = (bar_idx_reg + 3'd1) == limit;
    end

    // result assembly
    always_comb
    begin
        room = hit_size_reg - hit_off_reg;
        for (int k = 0; k < 8; k++)
        begin
            fwd_mask[8*k +: 8] = (4'(k) < item_reg.byte_count) ? 8'hff : 8'h00;
        end
        if (!found_reg)
        begin
            mem_status = pcibar_pkg::ST_NO_HIT;
        end
        else if (count_over || (room < 32'(item_reg.byte_count)))
        begin
            mem_status = pcibar_pkg::ST_BEYOND_BAR;
        end
        else if (!cmd_shadow_reg[pcibar_pkg::MSE_BIT])
        begin
            mem_status = pcibar_pkg::ST_MEM_DISABLED;
        end
        else
        begin
            mem_status = pcibar_pkg::ST_OK;
        end
        out_next = '0;
        if (is_mem)
        begin
            out_next.status = mem_status;
            if (found_reg)
            begin
                out_next.hit_bar    = hit_idx_reg;
                out_next.bar_offset = 64'(hit_off_reg);
            end
            if (is_write && (mem_status == pcibar_pkg::ST_OK))
            begin
                out_next.forward_data = item_reg.write_data & fwd_mask;
            end
        end
        else
        begin
            out_next.status = cfg_status;
            if (!is_write && (cfg_status == pcibar_pkg::ST_OK))
            begin
                out_next.read_data = acc_reg;
            end
        end
    end

    assign result = out_reg;

    // memory write port: clearing pass or config write
    always_comb
    begin
        mem_we    = cmd.clear_step || cmd.wr_byte;
        mem_waddr = cmd.clear_step ? clr_addr_reg : byte_addr;
        mem_wdata = cmd.clear_step ? 8'h00 : wr_byte_val;
    end

    // config space memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cfg_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= cfg_mem[byte_addr];
        end
    end

    // item, accumulator, search and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
            acc_reg  <= '0;
        end
        if (cmd.rd_capture)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (byte_idx_reg == 3'(k))
                begin
                    acc_reg[8*k +: 8] <= rdata_reg;
                end
            end
        end
        if (cmd.bar_step && bar_hit)
        begin
            hit_idx_reg  <= bar_idx_reg;
            hit_off_reg  <= diff[31:0];
            hit_size_reg <= size_cur;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    // counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            byte_idx_reg <= '0;
            bar_idx_reg  <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load_item)
            begin
                byte_idx_reg <= '0;
                bar_idx_reg  <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.rd_capture || cmd.wr_byte)
                begin
                    byte_idx_reg <= byte_idx_reg + 3'd1;
                end
                if (cmd.bar_step)
                begin
                    bar_idx_reg <= bar_idx_reg + 3'd1;
                    if (bar_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // shadows follow config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_shadow_reg <= '0;
            for (int k = 0; k < pcibar_pkg::BAR_AREA_BYTES; k++)
            begin
                bar_shadow_reg[k] <= '0;
            end
        end
        else if (cmd.wr_byte)
        begin
            if (byte_addr == AW'(pcibar_pkg::CMD_BYTE))
            begin
                cmd_shadow_reg <= wr_byte_val;
            end
            for (int k = 0; k < pcibar_pkg::BAR_AREA_BYTES; k++)
            begin
                if (byte_addr == AW'(pcibar_pkg::BAR_AREA + k))
                begin
                    bar_shadow_reg[k] <= wr_byte_val;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bars_in_use_reg   <= 3'd1;
            wide_bar_mode_reg <= 1'b0;
            for (int j = 0; j < pcibar_pkg::MAX_BARS; j++)
            begin
                bar_size_reg[j] <= 32'd4096;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcibar_pkg::CFG_BARS_IN_USE:   bars_in_use_reg   <= cfg_wdata[2:0];
                pcibar_pkg::CFG_WIDE_BAR_MODE: wide_bar_mode_reg <= cfg_wdata[0];
                default:
                begin
                    for (int j = 0; j < pcibar_pkg::MAX_BARS; j++)
                    begin
                        if (cfg_index == pcibar_pkg::CFG_BAR_SIZE_0 + 3'(j))
                        begin
                            bar_size_reg[j] <= cfg_wdata;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/core/pci_type0_config_and_bar_decode_unit.sv
// ---------------------------------------------------------------------------
// pci_type0_config_and_bar_decode_unit
// Type-0 endpoint front end: byte-wide config space and BAR address decoder
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   in_item  (pcibar_pkg::in_item_t)
//  out       out_valid / out_ready out_item (pcibar_pkg::out_item_t)
//  config    cfg_we                cfg_index, cfg_wdata
//
//  config read: each byte takes a read issue state and a capture state; config
//  write: a byte per state. memory op: BARs tried one per cycle on a shared
//  comparator, none if no BAR is decoded; rejected or zero-length config ops
//  skip both. the config space is a byte memory, one byte per access cycle.
//  after reset a clearing pass zeroes every config byte with in_ready low.
//  a result waits in the output register; the next item is accepted meanwhile.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pci_type0_config_and_bar_decode_unit #(
    parameter int CONFIG_BYTES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcibar_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcibar_pkg::out_item_t out_item,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_wdata
);

    pcibar_pkg::pcibar_cmd_t  cmd;
    pcibar_pkg::pcibar_stat_t stat;

    // sequencer
    pcibar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and compare
    pcibar_dpath #(
        .CONFIG_BYTES (CONFIG_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (out_item)
    );

    // checks
    `ASSERT_SAME(a_load_slot_free, cmd.load_out, !out_valid || out_ready, "result overwritten")
    `ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid, "loaded result not valid")
    `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready after accept")
    `ASSERT_SAME(a_clear_no_accept, cmd.clear_step, !in_ready, "item taken during clear")

endmodule
